### hdl/tbbd_pkg.sv
package tbbd_pkg;

  // Field widths
  localparam int unsigned PosWidth = 11;
  localparam int unsigned VelWidth = 12;
  localparam int unsigned AttackWidth = 11;
  localparam int unsigned NoteWidth = 3;
  localparam int unsigned ThresholdWidth = 4;
  localparam int unsigned FloorWidth = 4;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth = 11;
  localparam int unsigned ProductWidth = 2 * VelWidth;

  localparam int unsigned HistoryDepthDefault = 8;

  // Small bounces are lifted to this strength
  localparam logic [AttackWidth-1:0] AttackLift = AttackWidth'(10);

  // Register reset values
  localparam logic [ThresholdWidth-1:0] BounceThresholdReset = 4'b1111;
  localparam logic [PosWidth-1:0] AttackCeilingReset = PosWidth'(200);
  localparam logic [FloorWidth-1:0] AttackFloorReset = FloorWidth'(1);
  localparam logic [PosWidth-1:0] SplitPositionReset = PosWidth'(960);
  localparam logic [PosWidth-1:0] ZoneOneLimitReset = PosWidth'(200);
  localparam logic [PosWidth-1:0] ZoneTwoLimitReset = PosWidth'(400);

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_BOUNCE_THRESHOLD = 3'd0,
    REG_ATTACK_CEILING   = 3'd1,
    REG_ATTACK_FLOOR     = 3'd2,
    REG_SPLIT_POSITION   = 3'd3,
    REG_ZONE_ONE_LIMIT   = 3'd4,
    REG_ZONE_TWO_LIMIT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ZONE_ONE   = 2'd1,
    ZONE_TWO   = 2'd2,
    ZONE_THREE = 2'd3
  } zone_t;

  typedef struct packed {
    logic [PosWidth-1:0] pos_x;
    logic [PosWidth-1:0] pos_y;
  } position_t;

endpackage

### hdl/tbbd_if.sv
interface tbbd_sample_if;
  logic valid;
  logic ready;
  logic [tbbd_pkg::PosWidth-1:0] pos_x;
  logic [tbbd_pkg::PosWidth-1:0] pos_y;

  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink (input valid, input pos_x, input pos_y, output ready);
endinterface

interface tbbd_result_if;
  logic valid;
  logic ready;
  logic ball_index;
  logic signed [tbbd_pkg::VelWidth-1:0] vel_x;
  logic signed [tbbd_pkg::VelWidth-1:0] vel_y;
  logic [tbbd_pkg::AttackWidth-1:0] attack;
  logic [tbbd_pkg::NoteWidth-1:0] note;
  logic intro_pulse;

  modport source (output valid, output ball_index, output vel_x, output vel_y,
                  output attack, output note, output intro_pulse, input ready);
  modport sink (input valid, input ball_index, input vel_x, input vel_y,
                input attack, input note, input intro_pulse, output ready);
endinterface

interface tbbd_cfg_if;
  logic valid;
  logic ready;
  logic [tbbd_pkg::CfgIndexWidth-1:0] index;
  logic [tbbd_pkg::CfgDataWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/two_ball_bounce_detector_core.sv
// Two-ball bounce detector. Takes one tracked position per request on
// `sample`, assigns it to the left or right ball (x below split_position is
// left; x of 0 means a lost ball and goes to the ball opposite the previous
// request's ball) and returns one result per request on `result`: ball
// index, x/y velocity over HISTORY_DEPTH samples of that ball, bounce attack
// (0 when no bounce) and note. intro_pulse is set on the first lost-ball
// request after reset. Throughput is one request per clock while results are
// taken. A request is held in the input register and then in the result
// register, from which it is taken while result.ready is high. Per-ball state
// (history line, previous y velocity) is updated as a request moves from the
// input register into the result register, so the next request always sees
// it. A full result register that is not taken stalls the input register,
// which then deasserts sample.ready.
// Configuration writes on `cfg` are always accepted; write only while idle.
// Register indexes: 0 bounce_threshold (4b signed), 1 attack_ceiling,
// 2 attack_floor (4b), 3 split_position, 4 zone_one_limit, 5 zone_two_limit.
// Unknown indexes are ignored. Flags and per-ball state reset to zero, config to defaults.
module two_ball_bounce_detector_core #(
  parameter int unsigned HISTORY_DEPTH = tbbd_pkg::HistoryDepthDefault
) (
  input  logic   clk,
  input  logic   rst,
  tbbd_sample_if.sink   sample,
  tbbd_result_if.source result,
  tbbd_cfg_if.sink      cfg
);

  localparam int unsigned PW = tbbd_pkg::PosWidth;
  localparam int unsigned VW = tbbd_pkg::VelWidth;
  localparam int unsigned AW = tbbd_pkg::AttackWidth;
  localparam int unsigned NW = tbbd_pkg::NoteWidth;
  localparam int unsigned XW = tbbd_pkg::ProductWidth;
  localparam int unsigned TW = tbbd_pkg::ThresholdWidth;
  localparam int unsigned FW = tbbd_pkg::FloorWidth;

  // ---------------- configuration registers ----------------
  logic [TW-1:0] bounce_threshold;
  logic [PW-1:0] attack_ceiling;
  logic [FW-1:0] attack_floor;
  logic [PW-1:0] split_position;
  logic [PW-1:0] zone_one_limit;
  logic [PW-1:0] zone_two_limit;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounce_threshold <= tbbd_pkg::BounceThresholdReset;
      attack_ceiling   <= tbbd_pkg::AttackCeilingReset;
      attack_floor     <= tbbd_pkg::AttackFloorReset;
      split_position   <= tbbd_pkg::SplitPositionReset;
      zone_one_limit   <= tbbd_pkg::ZoneOneLimitReset;
      zone_two_limit   <= tbbd_pkg::ZoneTwoLimitReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        tbbd_pkg::REG_BOUNCE_THRESHOLD: bounce_threshold <= cfg.data[TW-1:0];
        tbbd_pkg::REG_ATTACK_CEILING:   attack_ceiling   <= cfg.data[PW-1:0];
        tbbd_pkg::REG_ATTACK_FLOOR:     attack_floor     <= cfg.data[FW-1:0];
        tbbd_pkg::REG_SPLIT_POSITION:   split_position   <= cfg.data[PW-1:0];
        tbbd_pkg::REG_ZONE_ONE_LIMIT:   zone_one_limit   <= cfg.data[PW-1:0];
        tbbd_pkg::REG_ZONE_TWO_LIMIT:   zone_two_limit   <= cfg.data[PW-1:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ---------------- input register ----------------
  logic                in_valid;
  tbbd_pkg::position_t in_pos;
  logic                advance;  // input register hands its request on

  assign advance      = in_valid && (!result.valid || result.ready);
  assign sample.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.ready) begin
      in_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_pos.pos_x <= sample.pos_x;
      in_pos.pos_y <= sample.pos_y;
    end
  end

  // ---------------- per-ball state ----------------
  logic                 last_ball;
  logic                 intro_sent;
  logic signed [VW-1:0] prev_vel_y [2];

  logic                 lost;
  logic                 ball;
  tbbd_pkg::position_t  oldest [2];
  tbbd_pkg::position_t  old_pos;

  // Lost ball jumps to the other side regardless of split
  assign lost = (in_pos.pos_x == '0);
  assign ball = lost ? ~last_ball : (in_pos.pos_x >= split_position);

  for (genvar b = 0; b < 2; b++) begin : g_ball
    tbbd_history #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_history (
      .clk    (clk),
      .rst    (rst),
      .shift  (advance && (ball == 1'(b))),
      .pos    (in_pos),
      .oldest (oldest[b])
    );
  end

  assign old_pos = oldest[ball];

  // ---------------- velocity and bounce ----------------
  logic signed [VW-1:0] vel_x;
  logic signed [VW-1:0] vel_y;
  logic signed [VW-1:0] prev_y;
  logic signed [XW-1:0] product;
  logic signed [XW-1:0] threshold_ext;
  logic                 bounce;
  logic [VW-1:0]        neg_vel_y;
  logic [AW-1:0]        mag;
  logic [AW-1:0]        floor_ext;
  logic [AW-1:0]        attack;

  assign vel_x = $signed({1'b0, in_pos.pos_x}) - $signed({1'b0, old_pos.pos_x});
  assign vel_y = $signed({1'b0, in_pos.pos_y}) - $signed({1'b0, old_pos.pos_y});
  assign prev_y = prev_vel_y[ball];
  assign product = XW'(vel_y) * XW'(prev_y);
  assign threshold_ext = $signed({{(XW-TW){bounce_threshold[TW-1]}}, bounce_threshold});
  assign bounce = (product < threshold_ext) && vel_y[VW-1];

  // |vel_y| never exceeds 2047 since positions are 11 bits
  assign neg_vel_y = -vel_y;
  assign mag       = neg_vel_y[AW-1:0];
  assign floor_ext = {{(AW-FW){1'b0}}, attack_floor};

  always_comb begin
    attack = '0;
    if (bounce) begin
      if (mag > attack_ceiling) begin
        attack = '0;                    // lost-ball jump
      end else if (mag > floor_ext && mag < tbbd_pkg::AttackLift) begin
        attack = tbbd_pkg::AttackLift;  // lift weak bounces
      end else if (mag < floor_ext) begin
        attack = '0;                    // noise
      end else begin
        attack = mag;
      end
    end
  end

  // ---------------- note ----------------
  tbbd_pkg::zone_t zone;
  logic [NW-1:0]   note;

  always_comb begin
    if (in_pos.pos_y < zone_one_limit) begin
      zone = tbbd_pkg::ZONE_ONE;
    end else if (in_pos.pos_y < zone_two_limit) begin
      zone = tbbd_pkg::ZONE_TWO;
    end else begin
      zone = tbbd_pkg::ZONE_THREE;
    end
  end

  // right ball doubles the zone
  assign note = ball ? {zone, 1'b0} : {1'b0, zone};

  // ---------------- state update ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      last_ball     <= 1'b0;
      intro_sent    <= 1'b0;
      prev_vel_y[0] <= '0;
      prev_vel_y[1] <= '0;
    end else if (advance) begin
      last_ball        <= ball;
      prev_vel_y[ball] <= vel_y;
      if (lost) begin
        intro_sent <= 1'b1;
      end
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.ball_index  <= ball;
      result.vel_x       <= vel_x;
      result.vel_y       <= vel_y;
      result.attack      <= attack;
      result.note        <= note;
      result.intro_pulse <= lost && !intro_sent;
    end
  end

`ifndef SYNTHESIS
  a_intro_sticky: assert property (@(posedge clk) disable iff (rst)
    intro_sent |=> intro_sent)
    else $error("intro_sent cleared without reset");

  a_intro_marks_sent: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.intro_pulse) |-> intro_sent)
    else $error("intro pulse shown but not recorded");

  a_attack_needs_fall: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.attack != '0) |-> result.vel_y[VW-1])
    else $error("attack on a non-falling ball");

  a_left_note_range: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ball_index) |-> (result.note != '0 &&
      result.note <= NW'(3)))
    else $error("left ball note out of range");

  a_right_note_even: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ball_index) |-> (result.note != '0 && !result.note[0]))
    else $error("right ball note not doubled");
`endif

endmodule

### hdl/tbbd_history.sv
// Per-ball position shift line. Holds the last HISTORY_DEPTH-1 positions;
// the oldest tap is the position seen HISTORY_DEPTH-1 requests ago.
module tbbd_history #(
  parameter int unsigned HISTORY_DEPTH = tbbd_pkg::HistoryDepthDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  tbbd_pkg::position_t pos,
  output tbbd_pkg::position_t oldest
);

  localparam int unsigned Taps = HISTORY_DEPTH - 1;

  tbbd_pkg::position_t line [Taps];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Taps; k++) begin
        line[k] <= '0;
      end
    end else if (shift) begin
      line[0] <= pos;
      for (int k = 1; k < Taps; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign oldest = line[Taps-1];

endmodule
